/* rtl/psrr_pkg.sv */
package psrr_pkg;

    // fixed field widths
    localparam int TYPE_W   = 3;
    localparam int PROC_W   = 4;
    localparam int CON_W    = 5;
    localparam int CPU_W    = 3;
    localparam int PC_W     = 16;
    localparam int CNT_W    = PC_W + 1;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 16;

    // default sizes
    localparam int MAX_PROCS_DEF    = 16;
    localparam int MAX_CPUS_DEF     = 8;
    localparam int MAX_CONSOLES_DEF = 32;

    // configuration register indexes and reset values
    localparam logic [CFG_IDX_W-1:0] CFG_MODE    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM = 1'b1;
    localparam logic [PC_W-1:0]      QUANTUM_RST = 16'd4;

    typedef enum logic [TYPE_W-1:0] {
        REQ_CREATE  = 3'd0,
        REQ_UPDATE  = 3'd1,
        REQ_BLOCK   = 3'd2,
        REQ_UNBLOCK = 3'd3,
        REQ_FINISH  = 3'd4,
        REQ_TICK    = 3'd5,
        REQ_ADD_CPU = 3'd6
    } req_t;

    typedef enum logic [2:0] {
        PH_FREE  = 3'd0,
        PH_READY = 3'd1,
        PH_EXEC  = 3'd2,
        PH_BLOCK = 3'd3,
        PH_EXIT  = 3'd4
    } phase_t;

    // one process table entry; counter msb marks an unassigned counter
    typedef struct packed {
        phase_t              phase;
        logic [CPU_W-1:0]    cpu;
        logic [CON_W-1:0]    console;
        logic [CNT_W-1:0]    counter;
    } proc_ent_t;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_LATCH,
        DP_DECODE,
        DP_RD_IDX,
        DP_RD_PID,
        DP_CR_CHK,
        DP_PID_CHK,
        DP_SC_CHK,
        DP_SC_EXPEL,
        DP_IDX_INC,
        DP_RD_READY,
        DP_DISPATCH,
        DP_RD_EXIT,
        DP_RETIRE
    } dp_op_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_CR_RD,
        S_CR_CHK,
        S_PID_RD,
        S_PID_CHK,
        S_SC_RD,
        S_SC_CHK,
        S_SC_REM,
        S_SC_NEXT,
        S_DISP_HEAD,
        S_DISPATCH,
        S_RET_HEAD,
        S_RETIRE,
        S_DONE
    } state_t;

    typedef struct packed {
        dp_op_t op;
    } cmd_t;

    typedef struct packed {
        req_t kind;
        logic range_bad;
        logic rr_on;
        logic ph_free;
        logic idx_last;
        logic run_cand;
        logic rem_busy;
        logic disp_ok;
        logic exit_ok;
    } stat_t;

endpackage

/* rtl/process_scheduler_fifo_rr_top.sv */
// channel   | handshake        | signals
// ----------+------------------+------------------------------------------------
// request   | start && !busy   | req_type proc_id console_id pc_value cpu_id
// result    | done (one cycle) | new_proc create_ok state_warning dispatch_*
//           |                  | retire_valid retire_proc retire_console
// config    | cfg_wr_en        | cfg_index cfg_data
//
// one item at a time; create searches the process table for a free slot,
// reading and checking one slot after another up to the last; a round-robin
// tick scans every slot and runs each running slot through the bit-serial
// remainder unit, then goes on to dispatch and retire. reset empties the
// queues and frees all slots at once. results are not held back by the
// receiver.
module process_scheduler_fifo_rr_top import psrr_pkg::*; #(
    parameter int MAX_PROCS    = MAX_PROCS_DEF,
    parameter int MAX_CPUS     = MAX_CPUS_DEF,
    parameter int MAX_CONSOLES = MAX_CONSOLES_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [TYPE_W-1:0]     req_type,
    input  logic [PROC_W-1:0]     proc_id,
    input  logic [CON_W-1:0]      console_id,
    input  logic [PC_W-1:0]       pc_value,
    input  logic [CPU_W-1:0]      cpu_id,
    output logic                  done,
    output logic [PROC_W-1:0]     new_proc,
    output logic                  create_ok,
    output logic                  state_warning,
    output logic                  dispatch_valid,
    output logic [PROC_W-1:0]     dispatch_proc,
    output logic [CPU_W-1:0]      dispatch_cpu,
    output logic                  retire_valid,
    output logic [PROC_W-1:0]     retire_proc,
    output logic [CON_W-1:0]      retire_console,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cmd_t  cmd;
    stat_t stat;

    // sequencer
    psrr_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(start), .stat(stat),
        .cmd(cmd), .busy(busy), .done(done)
    );

    // table, queues and result registers
    psrr_datapath #(
        .MAX_PROCS(MAX_PROCS), .MAX_CPUS(MAX_CPUS), .MAX_CONSOLES(MAX_CONSOLES)
    ) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .req_type(req_type), .proc_id(proc_id), .console_id(console_id),
        .pc_value(pc_value), .cpu_id(cpu_id),
        .new_proc(new_proc), .create_ok(create_ok), .state_warning(state_warning),
        .dispatch_valid(dispatch_valid), .dispatch_proc(dispatch_proc),
        .dispatch_cpu(dispatch_cpu), .retire_valid(retire_valid),
        .retire_proc(retire_proc), .retire_console(retire_console)
    );

endmodule

/* rtl/psrr_fifo.sv */
module psrr_fifo #(
    parameter int DEPTH = 2,
    parameter int W     = 1
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] push_data,
    input  logic         pop,
    output logic [W-1:0] head,
    output logic         empty,
    output logic         full
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  mem [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [W-1:0]  head_reg;
    logic          do_push, do_pop;

    assign full    = (cnt_reg == CW'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = head_reg;

    // pointer and count update with wrap
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // storage, head read registered
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
        head_reg <= mem[rd_ptr_reg];
    end

endmodule

/* rtl/psrr_rem.sv */
module psrr_rem import psrr_pkg::*; (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [PC_W-1:0] dividend,
    input  logic [PC_W-1:0] divisor,
    output logic            busy,
    output logic            zero
);

    localparam int STEP_W = $clog2(PC_W + 1);

    logic [STEP_W-1:0] step_reg, step_next;
    logic [PC_W-1:0]   rem_reg, rem_next;
    logic [PC_W-1:0]   dvd_reg, dvd_next;
    logic [PC_W:0]     trial;

    assign busy  = (step_reg != '0);
    assign zero  = (rem_reg == '0);
    assign trial = {rem_reg, dvd_reg[PC_W-1]};

    // restoring remainder, one dividend bit a cycle
    always_comb
    begin
        step_next = step_reg;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        if (start)
        begin
            step_next = STEP_W'(PC_W);
            rem_next  = '0;
            dvd_next  = dividend;
        end
        else if (busy)
        begin
            step_next = step_reg - 1'b1;
            dvd_next  = {dvd_reg[PC_W-2:0], 1'b0};
            if (trial >= {1'b0, divisor})
            begin
                rem_next = PC_W'(trial - {1'b0, divisor});
            end
            else
            begin
                rem_next = PC_W'(trial);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
    end

endmodule

/* rtl/psrr_datapath.sv */
module psrr_datapath import psrr_pkg::*; #(
    parameter int MAX_PROCS    = MAX_PROCS_DEF,
    parameter int MAX_CPUS     = MAX_CPUS_DEF,
    parameter int MAX_CONSOLES = MAX_CONSOLES_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  cmd_t                  cmd,
    output stat_t                 stat,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic [TYPE_W-1:0]     req_type,
    input  logic [PROC_W-1:0]     proc_id,
    input  logic [CON_W-1:0]      console_id,
    input  logic [PC_W-1:0]       pc_value,
    input  logic [CPU_W-1:0]      cpu_id,
    output logic [PROC_W-1:0]     new_proc,
    output logic                  create_ok,
    output logic                  state_warning,
    output logic                  dispatch_valid,
    output logic [PROC_W-1:0]     dispatch_proc,
    output logic [CPU_W-1:0]      dispatch_cpu,
    output logic                  retire_valid,
    output logic [PROC_W-1:0]     retire_proc,
    output logic [CON_W-1:0]      retire_console
);

    localparam int PIDX_W = $clog2(MAX_PROCS);

    // configuration
    logic            mode_reg;
    logic [PC_W-1:0] quantum_reg;

    // latched request
    req_t             type_reg;
    logic [PROC_W-1:0] pid_reg;
    logic [CON_W-1:0]  con_reg;
    logic [PC_W-1:0]   pc_reg;
    logic [CPU_W-1:0]  cpu_reg;

    // process table
    proc_ent_t         tbl [MAX_PROCS];
    logic [MAX_PROCS-1:0] valid_reg;
    proc_ent_t         rd_reg;
    logic [PIDX_W-1:0] rd_addr_q;
    logic              rd_en;
    logic [PIDX_W-1:0] rd_addr;
    logic              wr_en;
    logic [PIDX_W-1:0] wr_addr;
    proc_ent_t         wr_data;

    logic [PIDX_W-1:0] idx_reg, idx_next;

    // results
    logic [PROC_W-1:0] new_proc_reg, new_proc_next;
    logic              ok_reg, ok_next;
    logic              warn_reg, warn_next;
    logic              dv_reg, dv_next;
    logic [PROC_W-1:0] dp_reg, dp_next;
    logic [CPU_W-1:0]  dc_reg, dc_next;
    logic              rv_reg, rv_next;
    logic [PROC_W-1:0] rp_reg, rp_next;
    logic [CON_W-1:0]  rc_reg, rc_next;

    // queues
    logic              rq_push, rq_pop, rq_empty, rq_full;
    logic [PIDX_W-1:0] rq_din, rq_head;
    logic              cq_push, cq_pop, cq_empty, cq_full;
    logic [CPU_W-1:0]  cq_din, cq_head;
    logic              xq_push, xq_pop, xq_empty, xq_full;
    logic [PIDX_W-1:0] xq_din, xq_head;

    logic              rem_start, rem_busy, rem_zero;

    phase_t            ph;
    logic [PIDX_W-1:0] pid_slot;
    logic              pid_ok, con_bad, cpu_bad, idx_last, run_cand;

    assign ph       = valid_reg[rd_addr_q] ? rd_reg.phase : PH_FREE;
    assign pid_slot = PIDX_W'(pid_reg);
    assign pid_ok   = 32'(pid_reg) < MAX_PROCS;
    assign con_bad  = 32'(con_reg) >= MAX_CONSOLES;
    assign cpu_bad  = 32'(cpu_reg) >= MAX_CPUS;
    assign idx_last = (idx_reg == PIDX_W'(MAX_PROCS - 1));
    assign run_cand = (ph == PH_EXEC) && !rd_reg.counter[CNT_W-1];
    assign rem_start = (cmd.op == DP_SC_CHK) && run_cand;

    // status to the controller
    always_comb
    begin
        stat.kind      = type_reg;
        stat.range_bad = 1'b0;
        if (type_reg == REQ_CREATE)
        begin
            stat.range_bad = con_bad;
        end
        else if (type_reg inside {REQ_UPDATE, REQ_BLOCK, REQ_UNBLOCK, REQ_FINISH})
        begin
            stat.range_bad = !pid_ok;
        end
        stat.rr_on    = mode_reg && (quantum_reg != '0);
        stat.ph_free  = (ph == PH_FREE);
        stat.idx_last = idx_last;
        stat.run_cand = run_cand;
        stat.rem_busy = rem_busy;
        stat.disp_ok  = !rq_empty && !cq_empty;
        stat.exit_ok  = !xq_empty;
    end

    // per-operation work
    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = idx_reg;
        wr_en   = 1'b0;
        wr_addr = rd_addr_q;
        wr_data = rd_reg;
        rq_push = 1'b0;
        rq_din  = rd_addr_q;
        rq_pop  = 1'b0;
        cq_push = 1'b0;
        cq_din  = rd_reg.cpu;
        cq_pop  = 1'b0;
        xq_push = 1'b0;
        xq_din  = rd_addr_q;
        xq_pop  = 1'b0;
        idx_next      = idx_reg;
        new_proc_next = new_proc_reg;
        ok_next       = ok_reg;
        warn_next     = warn_reg;
        dv_next       = dv_reg;
        dp_next       = dp_reg;
        dc_next       = dc_reg;
        rv_next       = rv_reg;
        rp_next       = rp_reg;
        rc_next       = rc_reg;
        case (cmd.op)
            DP_LATCH:
            begin
                new_proc_next = '0;
                ok_next       = 1'b0;
                warn_next     = 1'b0;
                dv_next       = 1'b0;
                dp_next       = '0;
                dc_next       = '0;
                rv_next       = 1'b0;
                rp_next       = '0;
                rc_next       = '0;
            end
            DP_DECODE:
            begin
                idx_next = '0;
                if (stat.range_bad)
                begin
                    warn_next = 1'b1;
                end
                if (type_reg == REQ_ADD_CPU)
                begin
                    if (cpu_bad || cq_full)
                    begin
                        warn_next = 1'b1;
                    end
                    else
                    begin
                        cq_push = 1'b1;
                        cq_din  = cpu_reg;
                    end
                end
            end
            DP_RD_IDX:
            begin
                rd_en   = 1'b1;
                rd_addr = idx_reg;
            end
            DP_RD_PID:
            begin
                rd_en   = 1'b1;
                rd_addr = pid_slot;
            end
            DP_RD_READY:
            begin
                rd_en   = 1'b1;
                rd_addr = rq_head;
            end
            DP_RD_EXIT:
            begin
                rd_en   = 1'b1;
                rd_addr = xq_head;
            end
            DP_CR_CHK:
            begin
                if (ph == PH_FREE)
                begin
                    wr_en           = 1'b1;
                    wr_data.phase   = PH_READY;
                    wr_data.cpu     = '0;
                    wr_data.console = con_reg;
                    wr_data.counter = {1'b1, {PC_W{1'b0}}};
                    new_proc_next   = PROC_W'(rd_addr_q);
                    ok_next         = 1'b1;
                    rq_push         = 1'b1;
                    if (rq_full)
                    begin
                        warn_next = 1'b1;
                    end
                end
                else if (!idx_last)
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            DP_PID_CHK:
            begin
                if (ph == PH_FREE)
                begin
                    warn_next = 1'b1;
                end
                else
                begin
                    wr_en = 1'b1;
                    case (type_reg)
                        REQ_UPDATE:
                        begin
                            wr_data.counter = {1'b0, pc_reg};
                        end
                        REQ_BLOCK:
                        begin
                            if (ph == PH_EXEC)
                            begin
                                cq_push = 1'b1;
                                if (cq_full)
                                begin
                                    warn_next = 1'b1;
                                end
                            end
                            else
                            begin
                                warn_next = 1'b1;
                            end
                            wr_data.phase = PH_BLOCK;
                        end
                        REQ_UNBLOCK:
                        begin
                            if (ph != PH_BLOCK || rq_full)
                            begin
                                warn_next = 1'b1;
                            end
                            rq_push       = 1'b1;
                            wr_data.phase = PH_READY;
                        end
                        REQ_FINISH:
                        begin
                            if (ph == PH_EXEC)
                            begin
                                cq_push = 1'b1;
                                if (cq_full)
                                begin
                                    warn_next = 1'b1;
                                end
                            end
                            xq_push = 1'b1;
                            if (xq_full)
                            begin
                                warn_next = 1'b1;
                            end
                            wr_data.phase = PH_EXIT;
                        end
                        default:
                        begin
                            wr_en = 1'b0;
                        end
                    endcase
                end
            end
            DP_SC_EXPEL:
            begin
                if (rem_zero)
                begin
                    wr_en         = 1'b1;
                    wr_data.phase = PH_READY;
                    rq_push       = 1'b1;
                    cq_push       = 1'b1;
                    if (rq_full || cq_full)
                    begin
                        warn_next = 1'b1;
                    end
                end
            end
            DP_IDX_INC:
            begin
                if (!idx_last)
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            DP_DISPATCH:
            begin
                rq_pop = 1'b1;
                if (ph == PH_FREE)
                begin
                    warn_next = 1'b1;
                end
                else
                begin
                    cq_pop = 1'b1;
                    if (ph != PH_READY)
                    begin
                        warn_next = 1'b1;
                    end
                    wr_en         = 1'b1;
                    wr_data.phase = PH_EXEC;
                    wr_data.cpu   = cq_head;
                    dv_next       = 1'b1;
                    dp_next       = PROC_W'(rd_addr_q);
                    dc_next       = cq_head;
                end
            end
            DP_RETIRE:
            begin
                xq_pop = 1'b1;
                if (ph == PH_FREE)
                begin
                    warn_next = 1'b1;
                end
                else
                begin
                    if (ph != PH_EXIT)
                    begin
                        warn_next = 1'b1;
                    end
                    wr_en         = 1'b1;
                    wr_data.phase = PH_FREE;
                    rv_next       = 1'b1;
                    rp_next       = PROC_W'(rd_addr_q);
                    rc_next       = rd_reg.console;
                end
            end
            default:
            begin
            end
        endcase
    end

    // configuration and valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= 1'b0;
            quantum_reg <= QUANTUM_RST;
            valid_reg   <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    CFG_MODE:    mode_reg    <= cfg_data[0];
                    CFG_QUANTUM: quantum_reg <= cfg_data[PC_W-1:0];
                    default:     mode_reg    <= mode_reg;
                endcase
            end
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.op == DP_LATCH)
        begin
            type_reg <= req_t'(req_type);
            pid_reg  <= proc_id;
            con_reg  <= console_id;
            pc_reg   <= pc_value;
            cpu_reg  <= cpu_id;
        end
        if (wr_en)
        begin
            tbl[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_reg    <= tbl[rd_addr];
            rd_addr_q <= rd_addr;
        end
        idx_reg      <= idx_next;
        new_proc_reg <= new_proc_next;
        ok_reg       <= ok_next;
        warn_reg     <= warn_next;
        dv_reg       <= dv_next;
        dp_reg       <= dp_next;
        dc_reg       <= dc_next;
        rv_reg       <= rv_next;
        rp_reg       <= rp_next;
        rc_reg       <= rc_next;
    end

    // queues
    psrr_fifo #(.DEPTH(MAX_PROCS), .W(PIDX_W)) u_ready_q (
        .clk(clk), .rst_n(rst_n), .push(rq_push), .push_data(rq_din),
        .pop(rq_pop), .head(rq_head), .empty(rq_empty), .full(rq_full)
    );

    psrr_fifo #(.DEPTH(MAX_CPUS), .W(CPU_W)) u_cpu_q (
        .clk(clk), .rst_n(rst_n), .push(cq_push), .push_data(cq_din),
        .pop(cq_pop), .head(cq_head), .empty(cq_empty), .full(cq_full)
    );

    psrr_fifo #(.DEPTH(MAX_PROCS), .W(PIDX_W)) u_exit_q (
        .clk(clk), .rst_n(rst_n), .push(xq_push), .push_data(xq_din),
        .pop(xq_pop), .head(xq_head), .empty(xq_empty), .full(xq_full)
    );

    // quantum check
    psrr_rem u_rem (
        .clk(clk), .rst_n(rst_n), .start(rem_start),
        .dividend(rd_reg.counter[PC_W-1:0]), .divisor(quantum_reg),
        .busy(rem_busy), .zero(rem_zero)
    );

    assign new_proc       = new_proc_reg;
    assign create_ok      = ok_reg;
    assign state_warning  = warn_reg;
    assign dispatch_valid = dv_reg;
    assign dispatch_proc  = dp_reg;
    assign dispatch_cpu   = dc_reg;
    assign retire_valid   = rv_reg;
    assign retire_proc    = rp_reg;
    assign retire_console = rc_reg;

endmodule

/* rtl/psrr_ctrl.sv */
module psrr_ctrl import psrr_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    input  stat_t stat,
    output cmd_t  cmd,
    output logic  busy,
    output logic  done
);

    state_t state_reg, state_next;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (stat.kind == REQ_CREATE && !stat.range_bad)
                begin
                    state_next = S_CR_RD;
                end
                else if (stat.kind inside {REQ_UPDATE, REQ_BLOCK, REQ_UNBLOCK, REQ_FINISH}
                         && !stat.range_bad)
                begin
                    state_next = S_PID_RD;
                end
                else if (stat.kind == REQ_TICK)
                begin
                    state_next = stat.rr_on ? S_SC_RD : S_DISP_HEAD;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_CR_RD:     state_next = S_CR_CHK;
            S_CR_CHK:    state_next = (stat.ph_free || stat.idx_last) ? S_DONE : S_CR_RD;
            S_PID_RD:    state_next = S_PID_CHK;
            S_PID_CHK:   state_next = S_DONE;
            S_SC_RD:     state_next = S_SC_CHK;
            S_SC_CHK:    state_next = stat.run_cand ? S_SC_REM : S_SC_NEXT;
            S_SC_REM:
            begin
                if (!stat.rem_busy)
                begin
                    state_next = S_SC_NEXT;
                end
            end
            S_SC_NEXT:   state_next = stat.idx_last ? S_DISP_HEAD : S_SC_RD;
            S_DISP_HEAD: state_next = stat.disp_ok ? S_DISPATCH : S_RET_HEAD;
            S_DISPATCH:  state_next = S_RET_HEAD;
            S_RET_HEAD:  state_next = stat.exit_ok ? S_RETIRE : S_DONE;
            S_RETIRE:    state_next = S_DONE;
            S_DONE:      state_next = S_IDLE;
            default:     state_next = S_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd.op = DP_NOP;
        busy   = (state_reg != S_IDLE);
        done   = (state_reg == S_DONE);
        case (state_reg)
            S_IDLE:      cmd.op = start ? DP_LATCH : DP_NOP;
            S_DECODE:    cmd.op = DP_DECODE;
            S_CR_RD:     cmd.op = DP_RD_IDX;
            S_CR_CHK:    cmd.op = DP_CR_CHK;
            S_PID_RD:    cmd.op = DP_RD_PID;
            S_PID_CHK:   cmd.op = DP_PID_CHK;
            S_SC_RD:     cmd.op = DP_RD_IDX;
            S_SC_CHK:    cmd.op = DP_SC_CHK;
            S_SC_REM:    cmd.op = stat.rem_busy ? DP_NOP : DP_SC_EXPEL;
            S_SC_NEXT:   cmd.op = DP_IDX_INC;
            S_DISP_HEAD: cmd.op = DP_RD_READY;
            S_DISPATCH:  cmd.op = DP_DISPATCH;
            S_RET_HEAD:  cmd.op = DP_RD_EXIT;
            S_RETIRE:    cmd.op = DP_RETIRE;
            default:     cmd.op = DP_NOP;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule
